[hdl/sbda_pkg.sv]
// shared types and constants for the signed binary to decimal ascii converter
`timescale 1ns / 1ps

package sbda_pkg;

    localparam int BIN_W      = 32;
    localparam int MAX_DIGITS = 10;
    localparam int BCD_W      = 4 * MAX_DIGITS;
    localparam int SR_W       = BCD_W + BIN_W;
    localparam int CHAR_W     = 6;

    typedef logic signed [BIN_W-1:0] t_value;
    typedef logic [CHAR_W-1:0]       t_char;
    typedef logic [BCD_W-1:0]        t_bcd;
    typedef logic [SR_W-1:0]         t_sr;
    typedef logic [3:0]              t_cnt;

    localparam t_char ASCII_ZERO  = 6'd48;
    localparam t_char ASCII_NINE  = 6'd57;
    localparam t_char ASCII_MINUS = 6'd45;

endpackage

[hdl/sbda_in_if.sv]
// input channel: one signed integer per item
`timescale 1ns / 1ps

interface sbda_in_if;
    logic            valid;
    logic            ready;
    sbda_pkg::t_value value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

[hdl/sbda_out_if.sv]
// output channel: one ascii character per item with a last flag
`timescale 1ns / 1ps

interface sbda_out_if;
    logic            valid;
    logic            ready;
    sbda_pkg::t_char character;
    logic            last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

[hdl/signed_binary_to_decimal_ascii_top.sv]
// top level: signed 32-bit integer to decimal ascii text, one character per item
// the item passes stage 0, the double-dabble stages and the alignment stage into the
// serializer, which emits one character per cycle while o_out.ready is high; a number
//   has 1 to 11 characters, sent out by the single-character output serializer
// the six-stage conversion pipeline accepts a new item every cycle while it has room
// reset: i_rst_n synchronous active low, clears all valid bits and serializer flags
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sbda_in_if.sink           i_in,
    sbda_out_if.source        o_out
);

    // pipeline layout
    //   stage 0      : sign split and magnitude (two's complement negate)
    //   stages 1..4  : eight double-dabble steps each, 32 steps in total
    //   stage 5      : leading digit search and left alignment of the bcd digits
    //   serializer   : emits '-' if negative, then the digits, most significant first
    localparam int DD_STAGES = 4;
    localparam int LAST_STG  = DD_STAGES + 1;

    // eight shift-and-adjust steps; bcd digits live above the binary bits
    function automatic sbda_pkg::t_sr f_dd8(input sbda_pkg::t_sr sr);
        sbda_pkg::t_sr t;
        t = sr;
        for (int s = 0; s < 8; s++) begin
            for (int n = 0; n < sbda_pkg::MAX_DIGITS; n++) begin
                if (t[sbda_pkg::BIN_W + 4*n +: 4] >= 4'd5) begin
                    t[sbda_pkg::BIN_W + 4*n +: 4] = t[sbda_pkg::BIN_W + 4*n +: 4] + 4'd3;
                end
            end
            t = {t[sbda_pkg::SR_W-2:0], 1'b0};
        end
        return t;
    endfunction

    // per-stage valid bits and handshake enables
    logic [LAST_STG:0]  r_vld;
    logic [LAST_STG:0]  w_en;
    logic               w_ser_ld;

    // conversion stages
    sbda_pkg::t_sr      r_sr  [0:DD_STAGES];
    logic               r_neg [0:DD_STAGES];

    // alignment stage
    sbda_pkg::t_bcd     r_st5_dig;
    logic               r_st5_neg;
    sbda_pkg::t_cnt     r_st5_ndig;
    sbda_pkg::t_bcd     n_st5_dig;
    sbda_pkg::t_cnt     n_st5_ndig;
    sbda_pkg::t_cnt     w_top;

    // serializer
    logic               r_ovld;
    logic               r_sign_pend;
    sbda_pkg::t_bcd     r_dig;
    sbda_pkg::t_cnt     r_left;
    logic               w_last;
    logic               w_out_fire;

    // stage 0 input magnitude
    logic [sbda_pkg::BIN_W-1:0] n_mag;

    assign w_last     = !r_sign_pend && (r_left == 4'd1);
    assign w_out_fire = r_ovld && o_out.ready;
    // next number loads when the serializer is idle or its last character leaves
    assign w_ser_ld   = r_vld[LAST_STG] && (!r_ovld || (o_out.ready && w_last));

    // a stage takes new data when it is empty or its content moves on
    always_comb begin
        w_en[LAST_STG] = !r_vld[LAST_STG] || w_ser_ld;
        for (int k = LAST_STG - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign i_in.ready = w_en[0];

    always_comb begin
        if (i_in.value[sbda_pkg::BIN_W-1]) begin
            n_mag = ~i_in.value + 32'd1;
        end else begin
            n_mag = i_in.value;
        end
    end

    // highest nonzero digit; zero still gives one digit
    always_comb begin
        w_top = 4'd0;
        for (int n = 0; n < sbda_pkg::MAX_DIGITS; n++) begin
            if (r_sr[DD_STAGES][sbda_pkg::BIN_W + 4*n +: 4] != 4'd0) begin
                w_top = 4'(n);
            end
        end
        n_st5_ndig = w_top + 4'd1;
        n_st5_dig  = r_sr[DD_STAGES][sbda_pkg::SR_W-1:sbda_pkg::BIN_W]
                     << {4'(sbda_pkg::MAX_DIGITS - 1) - w_top, 2'b00};
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k <= LAST_STG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // conversion payload
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_sr[0]  <= {{sbda_pkg::BCD_W{1'b0}}, n_mag};
            r_neg[0] <= i_in.value[sbda_pkg::BIN_W-1];
        end
        for (int k = 1; k <= DD_STAGES; k++) begin
            if (w_en[k]) begin
                r_sr[k]  <= f_dd8(r_sr[k-1]);
                r_neg[k] <= r_neg[k-1];
            end
        end
        if (w_en[LAST_STG]) begin
            r_st5_dig  <= n_st5_dig;
            r_st5_neg  <= r_neg[DD_STAGES];
            r_st5_ndig <= n_st5_ndig;
        end
    end

    // serializer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld      <= 1'b0;
            r_sign_pend <= 1'b0;
        end else if (w_ser_ld) begin
            r_ovld      <= 1'b1;
            r_sign_pend <= r_st5_neg;
        end else if (w_out_fire) begin
            if (r_sign_pend) begin
                r_sign_pend <= 1'b0;
            end else if (r_left == 4'd1) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // serializer payload
    always_ff @(posedge i_clk) begin
        if (w_ser_ld) begin
            r_dig  <= r_st5_dig;
            r_left <= r_st5_ndig;
        end else if (w_out_fire && !r_sign_pend) begin
            r_dig  <= r_dig << 4;
            r_left <= r_left - 4'd1;
        end
    end

    assign o_out.valid     = r_ovld;
    assign o_out.last      = w_last;
    assign o_out.character = r_sign_pend ? sbda_pkg::ASCII_MINUS
                           : sbda_pkg::ASCII_ZERO
                             + {2'b00, r_dig[sbda_pkg::BCD_W-1 -: 4]};

`ifndef SYNTH
    // every character shown is '-' or a decimal digit
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.character == sbda_pkg::ASCII_MINUS) ||
                        ((o_out.character >= sbda_pkg::ASCII_ZERO) &&
                         (o_out.character <= sbda_pkg::ASCII_NINE)))
        else $error("character out of range");

    // a busy serializer always has between one and ten digits left
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> (r_left != 4'd0) && (r_left <= 4'(sbda_pkg::MAX_DIGITS)))
        else $error("serializer digit count out of range");

    // a stalled alignment stage keeps its number
    a_st5_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAST_STG] && !w_ser_ld) |=>
            (r_vld[LAST_STG] && $stable(r_st5_dig) && $stable(r_st5_ndig)))
        else $error("alignment stage lost data under stall");

    // the minus sign is never the final character
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.character == sbda_pkg::ASCII_MINUS) |-> !o_out.last)
        else $error("minus sign flagged as last");
`endif

endmodule
